// ----- rtl/servo_sweep_pwm_controller_defines.svh -----
// Assertion macros shared by the servo sweep RTL.
// Standalone header; taken in by the modules that carry assertions.
`ifndef SERVO_SWEEP_PWM_CONTROLLER_DEFINES_SVH
`define SERVO_SWEEP_PWM_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssp: next-cycle check failed");

`endif

// ----- rtl/ssp_pkg.sv -----
// Shared types and constants for the servo sweep PWM controller.
// No dependencies; imported by every module of the block.
package ssp_pkg;

    localparam int ANGLE_W       = 8;
    localparam int DELAY_W       = 16;
    localparam int PULSE_W       = 15;
    localparam int DUTY_W        = 16;
    localparam int OP_W          = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int DUTY_BITS_DEF = 16;

    localparam int FULL_ANGLE    = 180;
    localparam int FRAME_US      = 20000;

    // reciprocal divider: 180 = 4 * 45 and 20000 = 32 * 625, the odd parts by
    // multiplication with a rounded-up reciprocal; operands stay below 2^30
    localparam int RECIP_OP_W      = 30;
    localparam int RECIP_M_W       = 31;
    localparam int ANGLE_PRE_SHIFT = 2;
    localparam int ANGLE_SHIFT     = 27;
    localparam int FRAME_PRE_SHIFT = 5;
    localparam int FRAME_SHIFT     = 40;
    localparam logic [RECIP_M_W-1:0] ANGLE_RECIP = 31'd2982617;
    localparam logic [RECIP_M_W-1:0] FRAME_RECIP = 31'd1759218605;

    // signed pulse span and angle * span product
    localparam int SPAN_W        = PULSE_W + 1;
    localparam int PROD_A_W      = ANGLE_W + 1 + SPAN_W;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE  = 3'd5;

    localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE  = 8'd0;
    localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE  = 8'd180;
    localparam logic [ANGLE_W-1:0] RST_STEP_SIZE  = 8'd1;
    localparam logic [DELAY_W-1:0] RST_STEP_DELAY = 16'd20;
    localparam logic [PULSE_W-1:0] RST_MIN_PULSE  = 15'd1000;
    localparam logic [PULSE_W-1:0] RST_MAX_PULSE  = 15'd2000;

    typedef struct packed {
        logic accept;
        logic mul_a;
        logic div_a_start;
        logic pulse;
        logic mul_b;
        logic div_b_start;
        logic load_out;
    } ssp_cmd_t;

    typedef struct packed {
        logic has_result;
        logic drive;
        logic div_busy;
    } ssp_status_t;

endpackage

// ----- rtl/ssp_div.sv -----
// Constant divider by reciprocal multiplication: /180 for the pulse map, /20000 for duty.
// Depends on ssp_pkg; used by ssp_dpath. Operand and quotient are registered in turn.
module ssp_div #(
    parameter int DIV_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic             sel_frame,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);
    import ssp_pkg::*;

    localparam int PROD_W = RECIP_OP_W + RECIP_M_W;

    logic                  busy_reg;
    logic                  sel_reg;
    logic [RECIP_OP_W-1:0] opnd_reg;
    logic [DIV_W-1:0]      quot_reg;

    logic [DIV_W-1:0]      pre_shift;
    logic [RECIP_M_W-1:0]  recip;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     prod_shift;

    // strip the power-of-two factor first, then multiply by the reciprocal of the odd part
    assign pre_shift  = sel_frame ? (dividend >> FRAME_PRE_SHIFT)
                                  : (dividend >> ANGLE_PRE_SHIFT);
    assign recip      = sel_reg ? FRAME_RECIP : ANGLE_RECIP;
    assign prod       = PROD_W'(opnd_reg) * PROD_W'(recip);
    assign prod_shift = sel_reg ? (prod >> FRAME_SHIFT) : (prod >> ANGLE_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            opnd_reg <= RECIP_OP_W'(pre_shift);
            sel_reg  <= sel_frame;
        end
        if (busy_reg)
        begin
            quot_reg <= DIV_W'(prod_shift);
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

// ----- rtl/ssp_dpath.sv -----
// Datapath: configuration registers, sweep state, pulse map and duty scaling.
// Depends on ssp_pkg; instantiates ssp_div; driven by ssp_ctrl commands.
module ssp_dpath #(
    parameter int DUTY_BITS = ssp_pkg::DUTY_BITS_DEF,
    parameter int DIV_W     = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [ssp_pkg::OP_W-1:0]       operation,
    input  logic                           continuous_mode,
    input  ssp_pkg::ssp_cmd_t              cmd,
    output ssp_pkg::ssp_status_t           status,
    output logic [ssp_pkg::ANGLE_W-1:0]    angle,
    output logic [ssp_pkg::DUTY_W-1:0]     duty,
    output logic                           drive_update,
    output logic                           finished
);
    import ssp_pkg::*;

    localparam int PROD_B_W = PULSE_W + DUTY_BITS;
    localparam logic [PROD_B_W-1:0] DUTY_TOP = {{PULSE_W{1'b0}}, {DUTY_BITS{1'b1}}};

    // configuration
    logic [ANGLE_W-1:0] min_angle_reg;
    logic [ANGLE_W-1:0] max_angle_reg;
    logic [ANGLE_W-1:0] step_size_reg;
    logic [DELAY_W-1:0] step_delay_reg;
    logic [PULSE_W-1:0] min_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;

    // sweep state
    logic [ANGLE_W-1:0] sweep_angle_reg, sweep_angle_next;
    logic               moving_up_reg, moving_up_next;
    logic               sweep_active_reg, sweep_active_next;
    logic               loop_mode_reg, loop_mode_next;
    logic [DELAY_W-1:0] elapsed_reg, elapsed_next;

    // pending result
    logic [ANGLE_W-1:0] res_angle_reg;
    logic               res_drive_reg, res_drive_next;
    logic               res_done_reg, res_done_next;

    logic [DELAY_W-1:0]        elapsed_inc;
    logic signed [ANGLE_W+1:0] next_pos;
    logic signed [ANGLE_W+1:0] min_s;
    logic signed [ANGLE_W+1:0] max_s;
    logic [ANGLE_W-1:0]        limited_angle;

    // arithmetic
    logic signed [SPAN_W-1:0]   span;
    logic signed [PROD_A_W-1:0] prod_a_reg;
    logic [PROD_A_W-1:0]        prod_a_neg;
    logic [PROD_A_W-2:0]        mag_a;
    logic [PULSE_W:0]           q_mag;
    logic signed [PULSE_W+1:0]  q_signed;
    logic signed [PULSE_W+2:0]  pulse_sum;
    logic [PULSE_W-1:0]         pulse_clamped;
    logic [PULSE_W-1:0]         pulse_reg;
    logic [PROD_B_W-1:0]        prod_b_reg;
    logic [DUTY_W-1:0]          duty_sat;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic                 div_sel;
    logic                 div_busy;
    logic [DIV_W-1:0]     div_quot;

    // output register
    logic [ANGLE_W-1:0] angle_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic               drive_reg;
    logic               fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg  <= RST_MIN_ANGLE;
            max_angle_reg  <= RST_MAX_ANGLE;
            step_size_reg  <= RST_STEP_SIZE;
            step_delay_reg <= RST_STEP_DELAY;
            min_pulse_reg  <= RST_MIN_PULSE;
            max_pulse_reg  <= RST_MAX_PULSE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MIN_ANGLE:  min_angle_reg  <= cfg_data[ANGLE_W-1:0];
                CFG_MAX_ANGLE:  max_angle_reg  <= cfg_data[ANGLE_W-1:0];
                CFG_STEP_SIZE:  step_size_reg  <= cfg_data[ANGLE_W-1:0];
                CFG_STEP_DELAY: step_delay_reg <= cfg_data[DELAY_W-1:0];
                CFG_MIN_PULSE:  min_pulse_reg  <= cfg_data[PULSE_W-1:0];
                CFG_MAX_PULSE:  max_pulse_reg  <= cfg_data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // saturating tick count and the candidate angle for a step
    assign elapsed_inc = (elapsed_reg != {DELAY_W{1'b1}}) ? elapsed_reg + DELAY_W'(1)
                                                          : elapsed_reg;
    assign min_s    = $signed({2'b00, min_angle_reg});
    assign max_s    = $signed({2'b00, max_angle_reg});
    assign next_pos = moving_up_reg
                    ? $signed({2'b00, sweep_angle_reg}) + $signed({2'b00, step_size_reg})
                    : $signed({2'b00, sweep_angle_reg}) - $signed({2'b00, step_size_reg});

    always_comb
    begin
        sweep_angle_next  = sweep_angle_reg;
        moving_up_next    = moving_up_reg;
        sweep_active_next = sweep_active_reg;
        loop_mode_next    = loop_mode_reg;
        elapsed_next      = elapsed_reg;
        res_drive_next    = 1'b0;
        res_done_next     = 1'b0;
        case (operation)
            OP_START:
            begin
                sweep_active_next = 1'b1;
                loop_mode_next    = continuous_mode;
                sweep_angle_next  = min_angle_reg;
                moving_up_next    = 1'b1;
                elapsed_next      = '0;
                res_drive_next    = 1'b1;
            end
            OP_STOP:
            begin
                sweep_active_next = 1'b0;
            end
            OP_TICK:
            begin
                if (sweep_active_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= step_delay_reg)
                    begin
                        // upper bound is tested first, also with reversed bounds
                        if (next_pos >= max_s)
                        begin
                            sweep_angle_next = max_angle_reg;
                            if (loop_mode_reg)
                            begin
                                moving_up_next = 1'b0;
                                elapsed_next   = '0;
                                res_drive_next = 1'b1;
                            end
                            else
                            begin
                                sweep_active_next = 1'b0;
                                res_done_next     = 1'b1;
                            end
                        end
                        else if (next_pos <= min_s)
                        begin
                            sweep_angle_next = min_angle_reg;
                            moving_up_next   = 1'b1;
                            elapsed_next     = '0;
                            res_drive_next   = 1'b1;
                        end
                        else
                        begin
                            sweep_angle_next = next_pos[ANGLE_W-1:0];
                            elapsed_next     = '0;
                            res_drive_next   = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign limited_angle = (sweep_angle_next > ANGLE_W'(FULL_ANGLE)) ? ANGLE_W'(FULL_ANGLE)
                                                                     : sweep_angle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_angle_reg  <= '0;
            moving_up_reg    <= 1'b1;
            sweep_active_reg <= 1'b0;
            loop_mode_reg    <= 1'b0;
            elapsed_reg      <= '0;
            res_drive_reg    <= 1'b0;
            res_done_reg     <= 1'b0;
        end
        else if (cmd.accept)
        begin
            sweep_angle_reg  <= sweep_angle_next;
            moving_up_reg    <= moving_up_next;
            sweep_active_reg <= sweep_active_next;
            loop_mode_reg    <= loop_mode_next;
            elapsed_reg      <= elapsed_next;
            res_drive_reg    <= res_drive_next;
            res_done_reg     <= res_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_angle_reg <= limited_angle;
        end
    end

    // pulse = min + trunc(angle * span / 180)
    assign span       = $signed({1'b0, max_pulse_reg}) - $signed({1'b0, min_pulse_reg});
    assign prod_a_neg = -prod_a_reg;
    assign mag_a      = prod_a_reg[PROD_A_W-1] ? prod_a_neg[PROD_A_W-2:0]
                                               : prod_a_reg[PROD_A_W-2:0];
    assign q_mag      = div_quot[PULSE_W:0];
    assign q_signed   = prod_a_reg[PROD_A_W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign pulse_sum  = $signed({q_signed[PULSE_W+1], q_signed})
                      + $signed({3'b000, min_pulse_reg});

    // clamp negatives to zero and clamp at the frame length, where duty is already full scale
    always_comb
    begin
        if (pulse_sum[PULSE_W+2])
        begin
            pulse_clamped = '0;
        end
        else if (pulse_sum > (PULSE_W+3)'(FRAME_US))
        begin
            pulse_clamped = PULSE_W'(FRAME_US);
        end
        else
        begin
            pulse_clamped = pulse_sum[PULSE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_a)
        begin
            prod_a_reg <= $signed({1'b0, res_angle_reg}) * span;
        end
        if (cmd.pulse)
        begin
            pulse_reg <= pulse_clamped;
        end
        if (cmd.mul_b)
        begin
            prod_b_reg <= PROD_B_W'(pulse_reg) * DUTY_TOP;
        end
    end

    assign div_start    = cmd.div_a_start || cmd.div_b_start;
    assign div_dividend = cmd.div_b_start ? DIV_W'(prod_b_reg) : DIV_W'(mag_a);
    assign div_sel      = cmd.div_b_start;

    ssp_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .sel_frame (div_sel),
        .busy      (div_busy),
        .quotient  (div_quot)
    );

    assign duty_sat = (div_quot > DIV_W'({DUTY_W{1'b1}})) ? {DUTY_W{1'b1}}
                                                         : div_quot[DUTY_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            angle_reg <= res_angle_reg;
            duty_reg  <= res_drive_reg ? duty_sat : '0;
            drive_reg <= res_drive_reg;
            fin_reg   <= res_done_reg;
        end
    end

    assign status.has_result = res_drive_reg || res_done_reg;
    assign status.drive      = res_drive_reg;
    assign status.div_busy   = div_busy;

    assign angle        = angle_reg;
    assign duty         = duty_reg;
    assign drive_update = drive_reg;
    assign finished     = fin_reg;

endmodule

// ----- rtl/ssp_ctrl.sv -----
// Controller state machine: input/output handshakes and datapath sequencing.
// Depends on ssp_pkg and the assertion macros header.
`include "servo_sweep_pwm_controller_defines.svh"

module ssp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ssp_pkg::ssp_status_t status,
    output ssp_pkg::ssp_cmd_t    cmd
);
    import ssp_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_DECIDE    = 10'b00_0000_0010,
        ST_MUL_A     = 10'b00_0000_0100,
        ST_DIV_A_GO  = 10'b00_0000_1000,
        ST_DIV_A_RUN = 10'b00_0001_0000,
        ST_PULSE     = 10'b00_0010_0000,
        ST_MUL_B     = 10'b00_0100_0000,
        ST_DIV_B_GO  = 10'b00_1000_0000,
        ST_DIV_B_RUN = 10'b01_0000_0000,
        ST_LOAD      = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.accept      = in_valid && (state_reg == ST_IDLE);
        cmd.mul_a       = (state_reg == ST_MUL_A);
        cmd.div_a_start = (state_reg == ST_DIV_A_GO);
        cmd.pulse       = (state_reg == ST_PULSE);
        cmd.mul_b       = (state_reg == ST_MUL_B);
        cmd.div_b_start = (state_reg == ST_DIV_B_GO);
        cmd.load_out    = (state_reg == ST_LOAD) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // no result returns to idle; a completed single sweep carries no duty: skip the arithmetic
                if (!status.has_result)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.drive)
                begin
                    state_next = ST_MUL_A;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_MUL_A:     state_next = ST_DIV_A_GO;
            ST_DIV_A_GO:  state_next = ST_DIV_A_RUN;
            ST_DIV_A_RUN:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_PULSE;
                end
            end
            ST_PULSE:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = ST_DIV_B_GO;
            ST_DIV_B_GO:  state_next = ST_DIV_B_RUN;
            ST_DIV_B_RUN:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // hold the result until the downstream transaction completes
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `SSP_ASSERT_IMP(a_idle_div_quiet, clk, rst_n, state_reg == ST_IDLE, !status.div_busy)
    `SSP_ASSERT_NXT(a_div_starts, clk, rst_n, cmd.div_a_start || cmd.div_b_start, status.div_busy)
    `SSP_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_out, !out_valid_reg || out_ready)
    `SSP_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

// ----- rtl/servo_sweep_pwm_controller.sv -----
// Servo sweep controller with PWM duty output. Items are ticks, starts and stops;
// a start or a tick that steps the sweep yields one result with the new angle and
// its 16-bit duty, a completed single sweep yields one result flagged finished,
// and all other items yield nothing. Every item passes through a decide state;
// a sweep completion then goes straight to the output load, and a driven angle uses
// the shared reciprocal divider once for the /180 pulse map and once for the /20000
// duty scaling; a result that cannot leave holds the block for as long. One item
// is in flight at a time; a finished result waits in the output register while
// the next item is taken in. Configuration writes take effect at once.
module servo_sweep_pwm_controller #(
    parameter int DUTY_BITS = ssp_pkg::DUTY_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ssp_pkg::OP_W-1:0]       operation,
    input  logic                           continuous_mode,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ssp_pkg::ANGLE_W-1:0]    angle,
    output logic [ssp_pkg::DUTY_W-1:0]     duty,
    output logic                           drive_update,
    output logic                           finished
);
    import ssp_pkg::*;

    // divider width covers |angle * span| and pulse * (2^DUTY_BITS - 1)
    localparam int MAG_A_W = PROD_A_W - 1;
    localparam int DIV_W   = (MAG_A_W > PULSE_W + DUTY_BITS) ? MAG_A_W : PULSE_W + DUTY_BITS;

    ssp_cmd_t    cmd;
    ssp_status_t status;

    ssp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ssp_dpath #(
        .DUTY_BITS (DUTY_BITS),
        .DIV_W     (DIV_W)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .operation       (operation),
        .continuous_mode (continuous_mode),
        .cmd             (cmd),
        .status          (status),
        .angle           (angle),
        .duty            (duty),
        .drive_update    (drive_update),
        .finished        (finished)
    );

endmodule
